/* rtl/triple_vote_run_length_decoder_defines.svh */
// Assertion macros shared by the decoder RTL.
`ifndef TRIPLE_VOTE_RUN_LENGTH_DECODER_DEFINES_SVH
`define TRIPLE_VOTE_RUN_LENGTH_DECODER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TVRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tvrl: check failed");

// next-cycle implication
`define TVRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tvrl: check failed");

`endif

/* rtl/tvrl_pkg.sv */
// Shared types and constants for the triple-vote run-length decoder.
package tvrl_pkg;

    localparam int MAX_REPEAT_DEF = 15;

    localparam logic [7:0] CH_A       = 8'd65;
    localparam logic [7:0] CH_Z       = 8'd90;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] TWICE_LO   = 8'd28;
    localparam logic [7:0] TWICE_HI   = 8'd37;
    localparam logic [7:0] HOLD_LO    = 8'd38;
    localparam logic [7:0] HOLD_HI    = 8'd47;
    localparam logic [7:0] TWICE_OFS  = 8'd20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_BODY
    } state_t;

    // per-word plan produced by the decode stage
    typedef struct packed {
        logic [3:0] pre_digit;   // held digit emitted in the prefix run
        logic [1:0] body_cnt;    // words in the body run
        logic [7:0] body_char;
        logic       body_has;
        logic       body_err;
        logic       fin;
        logic       held_next;
        logic [3:0] held_val_next;
        logic       err_next;
    } plan_t;

endpackage

/* rtl/tvrl_decode.sv */
// Majority vote and symbol classification into an emit plan.
module tvrl_decode #(
    parameter int MAX_REPEAT = tvrl_pkg::MAX_REPEAT_DEF,
    parameter int CNT_W      = $clog2(MAX_REPEAT + 1)
) (
    input  logic [7:0]         copy_a,
    input  logic [7:0]         copy_b,
    input  logic [7:0]         copy_c,
    input  logic               final_symbol,
    input  logic               digit_held,
    input  logic [3:0]         held_val,
    input  logic               error_seen,
    output logic [CNT_W-1:0]   pre_cnt,
    output tvrl_pkg::plan_t    plan
);

    logic       ok;
    logic [7:0] sym;
    logic [7:0] hold_ofs;
    logic [1:0] p_cnt;
    logic [7:0] p_char;
    logic       p_has;
    logic       p_err;
    logic       p_hold;
    logic       is_count;

    always_comb begin
        ok  = 1'b1;
        sym = 8'd0;
        priority if (copy_a == copy_b) begin
            sym = copy_a;
        end else if (copy_b == copy_c) begin
            sym = copy_b;
        end else if (copy_c == copy_a) begin
            sym = copy_c;
        end else begin
            ok = 1'b0;
        end
    end

    assign hold_ofs = sym - tvrl_pkg::HOLD_LO;
    assign is_count = ok && (sym <= 8'(MAX_REPEAT));

    // plain symbol decode
    always_comb begin
        p_cnt  = 2'd0;
        p_char = 8'd0;
        p_has  = 1'b0;
        p_err  = 1'b0;
        p_hold = 1'b0;
        priority if (!ok) begin
            p_cnt = 2'd1;
            p_err = 1'b1;
        end else if ((sym >= tvrl_pkg::CH_A && sym <= tvrl_pkg::CH_Z)
                     || sym == tvrl_pkg::CH_NL) begin
            p_cnt  = 2'd1;
            p_char = sym;
            p_has  = 1'b1;
        end else if (sym >= tvrl_pkg::TWICE_LO && sym <= tvrl_pkg::TWICE_HI) begin
            p_cnt  = 2'd2;
            p_char = sym + tvrl_pkg::TWICE_OFS;
            p_has  = 1'b1;
        end else if (sym >= tvrl_pkg::HOLD_LO && sym <= tvrl_pkg::HOLD_HI) begin
            p_hold = 1'b1;
            if (final_symbol) begin
                p_cnt  = 2'd1;
                p_char = tvrl_pkg::CH_ZERO + {4'd0, hold_ofs[3:0]};
                p_has  = 1'b1;
            end
        end else begin
            p_cnt = 2'd1;
            p_err = 1'b1;
        end
    end

    always_comb begin
        pre_cnt            = '0;
        plan.pre_digit     = held_val;
        plan.body_cnt      = 2'd0;
        plan.body_char     = 8'd0;
        plan.body_has      = 1'b0;
        plan.body_err      = 1'b0;
        plan.fin           = final_symbol;
        plan.held_next     = digit_held;
        plan.held_val_next = held_val;
        plan.err_next      = error_seen;
        priority if (error_seen) begin
            plan.body_cnt = 2'd1;
            plan.body_err = 1'b1;
        end else if (digit_held && is_count) begin
            plan.held_next = 1'b0;
            pre_cnt        = CNT_W'(sym);
        end else begin
            if (digit_held) begin
                pre_cnt = CNT_W'(1);
            end
            plan.body_cnt      = p_cnt;
            plan.body_char     = p_char;
            plan.body_has      = p_has;
            plan.body_err      = p_err;
            plan.err_next      = p_err;
            plan.held_next     = p_hold && !final_symbol;
            plan.held_val_next = p_hold ? hold_ofs[3:0] : held_val;
        end
        if (final_symbol && pre_cnt == '0 && plan.body_cnt == 2'd0) begin
            plan.body_cnt = 2'd1;
        end
    end

endmodule

/* rtl/triple_vote_run_length_decoder.sv */
// Top level: triple-vote run-length decoder with emit sequencer and output register.
//
//  channel | ports                     | word
//  --------+---------------------------+----------------------------------------------
//  input   | s_tvalid s_tready s_tdata | copy_a, copy_b, copy_c; tlast = final_symbol
//  result  | m_tvalid m_tready m_tdata | out_char; tuser has_char, decode_error,
//          | m_tlast m_tuser           | run_last; tlast = stream_end
//
// An input word is taken, then a down-counter emits one result word per cycle while
// the result channel is not stalled: up to MAX_REPEAT words of a held digit, then up
// to two body words. s_tready is high only while the sequencer is idle. Result stalls
// hold the output register and the counter. Synchronous active-low reset clears all
// control state.
`include "triple_vote_run_length_decoder_defines.svh"

module triple_vote_run_length_decoder #(
    parameter int MAX_REPEAT = tvrl_pkg::MAX_REPEAT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] copy_a, [15:8] copy_b, [23:16] copy_c
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [0] has_char, [1] decode_error, [2] run_last
);

    localparam int CNT_W = $clog2(MAX_REPEAT + 1);

    tvrl_pkg::state_t state_reg, state_next;
    tvrl_pkg::plan_t  plan_reg, plan_next, plan_dec;

    logic [CNT_W-1:0] pre_cnt_reg, pre_cnt_next, pre_cnt_dec;
    logic [1:0]       body_cnt_reg, body_cnt_next;
    logic             digit_held_reg, digit_held_next;
    logic [3:0]       held_val_reg, held_val_next;
    logic             error_seen_reg, error_seen_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_char_reg, m_char_next;
    logic       m_has_reg, m_has_next;
    logic       m_err_reg, m_err_next;
    logic       m_end_reg, m_end_next;
    logic       m_last_reg, m_last_next;

    logic accept;
    logic out_free;
    logic emit_pre;
    logic emit_body;
    logic pre_done;

    tvrl_decode #(
        .MAX_REPEAT (MAX_REPEAT),
        .CNT_W      (CNT_W)
    ) u_decode (
        .copy_a       (s_tdata[7:0]),
        .copy_b       (s_tdata[15:8]),
        .copy_c       (s_tdata[23:16]),
        .final_symbol (s_tlast),
        .digit_held   (digit_held_reg),
        .held_val     (held_val_reg),
        .error_seen   (error_seen_reg),
        .pre_cnt      (pre_cnt_dec),
        .plan         (plan_dec)
    );

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign emit_pre  = (state_reg == tvrl_pkg::ST_PRE) && out_free;
    assign emit_body = (state_reg == tvrl_pkg::ST_BODY) && out_free;
    assign pre_done  = pre_cnt_reg == CNT_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tvrl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (pre_cnt_dec != '0) begin
                        state_next = tvrl_pkg::ST_PRE;
                    end else if (plan_dec.body_cnt != 2'd0) begin
                        state_next = tvrl_pkg::ST_BODY;
                    end
                end
            end
            tvrl_pkg::ST_PRE: begin
                if (out_free && pre_done) begin
                    state_next = (body_cnt_reg != 2'd0) ? tvrl_pkg::ST_BODY
                                                         : tvrl_pkg::ST_IDLE;
                end
            end
            tvrl_pkg::ST_BODY: begin
                if (out_free && body_cnt_reg == 2'd1) begin
                    state_next = tvrl_pkg::ST_IDLE;
                end
            end
            default: state_next = tvrl_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready        = state_reg == tvrl_pkg::ST_IDLE;
        plan_next       = plan_reg;
        pre_cnt_next    = pre_cnt_reg;
        body_cnt_next   = body_cnt_reg;
        digit_held_next = digit_held_reg;
        held_val_next   = held_val_reg;
        error_seen_next = error_seen_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_char_next     = m_char_reg;
        m_has_next      = m_has_reg;
        m_err_next      = m_err_reg;
        m_end_next      = m_end_reg;
        m_last_next     = m_last_reg;
        if (accept) begin
            plan_next       = plan_dec;
            pre_cnt_next    = pre_cnt_dec;
            body_cnt_next   = plan_dec.body_cnt;
            digit_held_next = plan_dec.held_next;
            held_val_next   = plan_dec.held_val_next;
            error_seen_next = plan_dec.err_next;
        end
        if (emit_pre) begin
            pre_cnt_next = pre_cnt_reg - CNT_W'(1);
            m_valid_next = 1'b1;
            m_char_next  = tvrl_pkg::CH_ZERO + {4'd0, plan_reg.pre_digit};
            m_has_next   = 1'b1;
            m_err_next   = 1'b0;
            m_last_next  = pre_done && body_cnt_reg == 2'd0;
            m_end_next   = pre_done && body_cnt_reg == 2'd0 && plan_reg.fin;
        end
        if (emit_body) begin
            body_cnt_next = body_cnt_reg - 2'd1;
            m_valid_next  = 1'b1;
            m_char_next   = plan_reg.body_char;
            m_has_next    = plan_reg.body_has;
            m_err_next    = plan_reg.body_err;
            m_last_next   = body_cnt_reg == 2'd1;
            m_end_next    = body_cnt_reg == 2'd1 && plan_reg.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tvrl_pkg::ST_IDLE;
            pre_cnt_reg    <= '0;
            body_cnt_reg   <= 2'd0;
            digit_held_reg <= 1'b0;
            held_val_reg   <= 4'd0;
            error_seen_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pre_cnt_reg    <= pre_cnt_next;
            body_cnt_reg   <= body_cnt_next;
            digit_held_reg <= digit_held_next;
            held_val_reg   <= held_val_next;
            error_seen_reg <= error_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        plan_reg   <= plan_next;
        m_char_reg <= m_char_next;
        m_has_reg  <= m_has_next;
        m_err_reg  <= m_err_next;
        m_end_reg  <= m_end_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_end_reg;
    assign m_tuser  = {m_last_reg, m_err_reg, m_has_reg};

    `TVRL_ASSERT_NEXT(a_err_sticky, error_seen_reg, error_seen_reg)
    `TVRL_ASSERT_NOW(a_pre_nonzero, state_reg == tvrl_pkg::ST_PRE, pre_cnt_reg != '0)
    `TVRL_ASSERT_NOW(a_body_nonzero, state_reg == tvrl_pkg::ST_BODY, body_cnt_reg != 2'd0)
    `TVRL_ASSERT_NOW(a_empty_is_end, m_valid_reg && !m_has_reg && !m_err_reg, m_end_reg)
    `TVRL_ASSERT_NOW(a_end_is_last, m_valid_reg && m_end_reg, m_last_reg)

endmodule
